[rtl/nfa_active_set_stepper_unit_defines.svh]
`ifndef NFA_ACTIVE_SET_STEPPER_UNIT_DEFINES_SVH
`define NFA_ACTIVE_SET_STEPPER_UNIT_DEFINES_SVH

// same-cycle implication
`define NFAS_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NFAS_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/nfas_pkg.sv]
package nfas_pkg;

  localparam int DATA_W   = 64;
  localparam int OPC_W    = 3;
  localparam int SYM_IN_W = 5;
  localparam int NODE_W   = 6;
  localparam int HCNT_W   = 7;

  localparam int NODE_COUNT_DEF    = 64;
  localparam int SYMBOL_COUNT_DEF  = 32;
  localparam int HISTORY_DEPTH_DEF = 64;

  typedef enum logic [OPC_W-1:0] {
    OP_STEP     = 3'd0,
    OP_UNDO     = 3'd1,
    OP_RESTART  = 3'd2,
    OP_ADD_EDGE = 3'd3,
    OP_SET_TERM = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EDGE,
    ST_UNDO,
    ST_FINISH
  } st_t;

  typedef struct packed {
    logic [DATA_W-1:0] active;
    logic [DATA_W-1:0] terminal;
    logic              undo_ignored;
    logic [HCNT_W-1:0] history_count;
  } res_t;

endpackage

[rtl/nfas_out_stage.sv]
module nfas_out_stage import nfas_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ld,
  input  res_t              res,
  output logic              can_ld,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_active_mask,
  output logic              out_unique_terminal,
  output logic [NODE_W-1:0] out_lowest_active,
  output logic              out_none_active,
  output logic              out_undo_ignored,
  output logic [HCNT_W-1:0] out_history_count
);

  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] mask_r;
  logic              uniq_r, none_r, ign_r;
  logic [NODE_W-1:0] low_r;
  logic [HCNT_W-1:0] hcnt_r;

  logic [DATA_W-1:0] act_term;
  logic [DATA_W-1:0] low_oh;
  logic              uniq_c;
  logic [NODE_W-1:0] low_c;

  assign can_ld = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (ld) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  // one active terminal: nonzero and a power of two
  always_comb begin
    act_term = res.active & res.terminal;
    uniq_c   = (act_term != '0) && ((act_term & (act_term - 1'b1)) == '0);
    low_oh   = res.active & (~res.active + 1'b1);
    low_c    = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (low_oh[i]) begin
        low_c = low_c | NODE_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      mask_r <= res.active;
      uniq_r <= uniq_c;
      low_r  <= low_c;
      none_r <= (res.active == '0);
      ign_r  <= res.undo_ignored;
      hcnt_r <= res.history_count;
    end
  end

  assign out_valid           = valid_r;
  assign out_active_mask     = mask_r;
  assign out_unique_terminal = uniq_r;
  assign out_lowest_active   = low_r;
  assign out_none_active     = none_r;
  assign out_undo_ignored    = ign_r;
  assign out_history_count   = hcnt_r;

endmodule

[rtl/nfa_active_set_stepper_unit.sv]
// channel | beat fields                                           | flow
// in_     | opcode, symbol, from_node, to_node                    | in_valid / in_ready
// out_    | active_mask, unique_terminal, lowest_active,          | out_valid / out_ready
//         | none_active, undo_ignored, history_count              |
//
// Step: the scan visits every node in turn and reads the successor row of each active
// node through the single read port of the successor memory.
// Add edge and undo do a memory read, then a write or load; an ignored add edge or
// undo, and the rest, skip the memory step.
// After reset the successor memory is zeroed one row a cycle, all
// NODE_COUNT * 2**ceil(log2(SYMBOL_COUNT)) rows, with in_ready low.
// A held result stalls the block only once the next result is ready to be written.
module nfa_active_set_stepper_unit import nfas_pkg::*; #(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int SYMBOL_COUNT  = SYMBOL_COUNT_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPC_W-1:0]    in_opcode,
  input  logic [SYM_IN_W-1:0] in_symbol,
  input  logic [NODE_W-1:0]   in_from_node,
  input  logic [NODE_W-1:0]   in_to_node,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DATA_W-1:0]   out_active_mask,
  output logic                out_unique_terminal,
  output logic [NODE_W-1:0]   out_lowest_active,
  output logic                out_none_active,
  output logic                out_undo_ignored,
  output logic [HCNT_W-1:0]   out_history_count
);

`include "nfa_active_set_stepper_unit_defines.svh"

  localparam int SYM_W      = $clog2(SYMBOL_COUNT);
  localparam int NODE_IDX_W = $clog2(NODE_COUNT);
  localparam int ROW_ADDR_W = NODE_IDX_W + SYM_W;
  localparam int ROWS       = NODE_COUNT << SYM_W;
  localparam int HIST_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W     = $clog2(HISTORY_DEPTH + 1);

  st_t state_r, state_nxt;

  logic [ROW_ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [NODE_IDX_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic [NODE_COUNT-1:0] acc_r, acc_nxt;
  logic [NODE_COUNT-1:0] active_r, active_nxt;
  logic [NODE_COUNT-1:0] term_r, term_nxt;
  logic [HIST_W-1:0]     top_r, top_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic                  ign_r, ign_nxt;
  logic [SYM_W-1:0]      sym_idx_r, sym_idx_nxt;
  logic                  sym_ok_r, sym_ok_nxt;
  logic [ROW_ADDR_W-1:0] edge_addr_r, edge_addr_nxt;
  logic [NODE_COUNT-1:0] edge_bit_r, edge_bit_nxt;

  logic [NODE_COUNT-1:0] succ_mem [ROWS];
  logic [NODE_COUNT-1:0] succ_rdata_r;
  logic                  succ_rvld_r;
  logic                  succ_re, succ_we;
  logic [ROW_ADDR_W-1:0] succ_raddr, succ_waddr;
  logic [NODE_COUNT-1:0] succ_wdata;

  logic [NODE_COUNT-1:0] hist_mem [HISTORY_DEPTH];
  logic [NODE_COUNT-1:0] hist_rdata_r;
  logic                  hist_we, hist_re;

  logic [SYM_W-1:0]      in_sym_idx;
  logic [NODE_IDX_W-1:0] in_src_idx, in_dst_idx;
  logic                  in_sym_ok, in_src_ok, in_edge_ok;
  logic [HIST_W-1:0]     top_inc, top_dec;
  logic [NODE_COUNT-1:0] acc_fold;
  logic                  scan_last, clr_last;
  logic                  out_ld, out_can_ld;
  res_t                  res;

  assign in_sym_idx = SYM_W'(in_symbol);
  assign in_src_idx = NODE_IDX_W'(in_from_node);
  assign in_dst_idx = NODE_IDX_W'(in_to_node);
  assign in_sym_ok  = 32'(in_symbol) < SYMBOL_COUNT;
  assign in_src_ok  = 32'(in_from_node) < NODE_COUNT;
  assign in_edge_ok = in_sym_ok && in_src_ok && (32'(in_to_node) < NODE_COUNT);

  assign top_inc = (top_r == HIST_W'(HISTORY_DEPTH - 1)) ? '0 : top_r + 1'b1;
  assign top_dec = (top_r == '0) ? HIST_W'(HISTORY_DEPTH - 1) : top_r - 1'b1;

  assign acc_fold  = acc_r | (succ_rvld_r ? succ_rdata_r : '0);
  assign scan_last = (scan_cnt_r == NODE_IDX_W'(NODE_COUNT - 1));
  assign clr_last  = (clr_cnt_r == ROW_ADDR_W'(ROWS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            OP_STEP:     state_nxt = ST_SCAN;
            OP_UNDO:     state_nxt = (fill_r == '0) ? ST_FINISH : ST_UNDO;
            OP_ADD_EDGE: state_nxt = in_edge_ok ? ST_EDGE : ST_FINISH;
            default:     state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:  state_nxt = ST_FINISH;
      ST_EDGE:   state_nxt = ST_FINISH;
      ST_UNDO:   state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_can_ld) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready      = 1'b0;
    succ_re       = 1'b0;
    succ_raddr    = {scan_cnt_r, sym_idx_r};
    succ_we       = 1'b0;
    succ_waddr    = clr_cnt_r;
    succ_wdata    = '0;
    hist_we       = 1'b0;
    hist_re       = 1'b0;
    out_ld        = 1'b0;
    clr_cnt_nxt   = clr_cnt_r;
    scan_cnt_nxt  = scan_cnt_r;
    acc_nxt       = acc_r;
    active_nxt    = active_r;
    term_nxt      = term_r;
    top_nxt       = top_r;
    fill_nxt      = fill_r;
    ign_nxt       = ign_r;
    sym_idx_nxt   = sym_idx_r;
    sym_ok_nxt    = sym_ok_r;
    edge_addr_nxt = edge_addr_r;
    edge_bit_nxt  = edge_bit_r;
    case (state_r)
      ST_CLEAR: begin
        succ_we     = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ign_nxt       = 1'b0;
          acc_nxt       = '0;
          scan_cnt_nxt  = '0;
          sym_idx_nxt   = in_sym_idx;
          sym_ok_nxt    = in_sym_ok;
          edge_addr_nxt = {in_src_idx, in_sym_idx};
          edge_bit_nxt  = NODE_COUNT'(1) << in_dst_idx;
          case (in_opcode)
            OP_STEP: begin
              hist_we = 1'b1;
              top_nxt = top_inc;
              if (fill_r < FILL_W'(HISTORY_DEPTH)) fill_nxt = fill_r + 1'b1;
            end
            OP_UNDO: begin
              if (fill_r == '0) begin
                ign_nxt = 1'b1;
              end else begin
                hist_re  = 1'b1;
                top_nxt  = top_dec;
                fill_nxt = fill_r - 1'b1;
              end
            end
            OP_RESTART: begin
              active_nxt = NODE_COUNT'(1);
            end
            OP_ADD_EDGE: begin
              succ_re    = in_edge_ok;
              succ_raddr = {in_src_idx, in_sym_idx};
            end
            OP_SET_TERM: begin
              if (in_src_ok) term_nxt = term_r | (NODE_COUNT'(1) << in_src_idx);
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        succ_re      = active_r[scan_cnt_r] && sym_ok_r;
        acc_nxt      = acc_fold;
        scan_cnt_nxt = scan_cnt_r + 1'b1;
      end
      ST_DRAIN: begin
        active_nxt = acc_fold;
      end
      ST_EDGE: begin
        succ_we    = 1'b1;
        succ_waddr = edge_addr_r;
        succ_wdata = succ_rdata_r | edge_bit_r;
      end
      ST_UNDO: begin
        active_nxt = hist_rdata_r;
      end
      ST_FINISH: begin
        out_ld = out_can_ld;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      scan_cnt_r  <= '0;
      active_r    <= NODE_COUNT'(1);
      term_r      <= '0;
      top_r       <= '0;
      fill_r      <= '0;
      ign_r       <= 1'b0;
      succ_rvld_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      active_r    <= active_nxt;
      term_r      <= term_nxt;
      top_r       <= top_nxt;
      fill_r      <= fill_nxt;
      ign_r       <= ign_nxt;
      succ_rvld_r <= succ_re;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    sym_idx_r   <= sym_idx_nxt;
    sym_ok_r    <= sym_ok_nxt;
    edge_addr_r <= edge_addr_nxt;
    edge_bit_r  <= edge_bit_nxt;
  end

  // successor rows, one per (node, symbol)
  always_ff @(posedge clk) begin
    if (succ_we) succ_mem[succ_waddr] <= succ_wdata;
    if (succ_re) succ_rdata_r <= succ_mem[succ_raddr];
  end

  // history ring
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[top_r] <= active_r;
    if (hist_re) hist_rdata_r <= hist_mem[top_dec];
  end

  assign res.active        = DATA_W'(active_r);
  assign res.terminal      = DATA_W'(term_r);
  assign res.undo_ignored  = ign_r;
  assign res.history_count = HCNT_W'(fill_r);

  nfas_out_stage u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ld                  (out_ld),
    .res                 (res),
    .can_ld              (out_can_ld),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_active_mask     (out_active_mask),
    .out_unique_terminal (out_unique_terminal),
    .out_lowest_active   (out_lowest_active),
    .out_none_active     (out_none_active),
    .out_undo_ignored    (out_undo_ignored),
    .out_history_count   (out_history_count)
  );

  `NFAS_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1,
    fill_r <= FILL_W'(HISTORY_DEPTH), "history fill above depth")
  `NFAS_ASSERT_NEXT(a_restart_root, clk, rst_n,
    in_valid && in_ready && in_opcode == OP_RESTART,
    active_r == NODE_COUNT'(1), "restart did not return to root")
  `NFAS_ASSERT_NEXT(a_undo_empty, clk, rst_n,
    in_valid && in_ready && in_opcode == OP_UNDO && fill_r == '0,
    ign_r && fill_r == '0 && $stable(top_r) && $stable(active_r),
    "undo on empty history changed state")
  `NFAS_ASSERT_NEXT(a_step_push, clk, rst_n,
    in_valid && in_ready && in_opcode == OP_STEP && fill_r < FILL_W'(HISTORY_DEPTH),
    fill_r == $past(fill_r) + 1'b1, "step beat did not push history")

endmodule

[tb/nfa_active_set_stepper_unit_test.sv]
module nfa_active_set_stepper_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nfas_pkg::*;

  localparam logic [OPC_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OPC_W-1:0] OP_RSVD_7 = 3'd7;
  localparam logic [OPC_W-1:0] OP_RSVD_6 = 3'd6;
  localparam int ROWS         = NODE_COUNT_DEF * SYMBOL_COUNT_DEF;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_BEATS  = 130;
  localparam int BURST_STEPS  = 66;

  typedef struct packed {
    logic [DATA_W-1:0] mask;
    logic              uniq;
    logic [NODE_W-1:0] low;
    logic              none;
    logic              ign;
    logic [HCNT_W-1:0] cnt;
  } nfa_view_t;

  class nfa_scoreboard;
    bit [DATA_W-1:0] succ_rows [ROWS];
    bit [DATA_W-1:0] saved_sets [HISTORY_DEPTH_DEF];
    bit [DATA_W-1:0] term_set;
    bit [DATA_W-1:0] live_set;
    int saved_top;
    int saved_fill;
    int errors;
    nfa_view_t due_q[$];

    function new();
      live_set = 1;
    endfunction

    function void note_beat(logic [OPC_W-1:0] op, logic [SYM_IN_W-1:0] sym,
                            logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
      bit [DATA_W-1:0] nxt;
      nfa_view_t v;
      v.ign = 1'b0;
      case (op)
        OP_STEP: begin
          nxt = '0;
          if (sym < SYMBOL_COUNT_DEF) begin
            for (int n = 0; n < NODE_COUNT_DEF; n++)
              if (live_set[n]) nxt |= succ_rows[n * SYMBOL_COUNT_DEF + sym];
          end
          saved_sets[saved_top] = live_set;
          saved_top = (saved_top + 1) % HISTORY_DEPTH_DEF;
          if (saved_fill < HISTORY_DEPTH_DEF) saved_fill++;
          live_set = nxt;
        end
        OP_UNDO: begin
          if (saved_fill == 0) begin
            v.ign = 1'b1;
          end else begin
            saved_top = (saved_top + HISTORY_DEPTH_DEF - 1) % HISTORY_DEPTH_DEF;
            live_set = saved_sets[saved_top];
            saved_fill--;
          end
        end
        OP_RESTART: live_set = 1;
        OP_ADD_EDGE: begin
          if (sym < SYMBOL_COUNT_DEF && src < NODE_COUNT_DEF && dst < NODE_COUNT_DEF)
            succ_rows[src * SYMBOL_COUNT_DEF + sym][dst] = 1'b1;
        end
        OP_SET_TERM: begin
          if (src < NODE_COUNT_DEF) term_set[src] = 1'b1;
        end
        default: ;
      endcase
      v.mask = live_set;
      v.uniq = ($countones(live_set & term_set) == 1);
      v.low  = '0;
      for (int i = DATA_W - 1; i >= 0; i--)
        if (live_set[i]) v.low = NODE_W'(i);
      v.none = (live_set == 0);
      v.cnt  = HCNT_W'(saved_fill);
      due_q = {due_q, v};
    endfunction

    function void cmp(string what, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, what, exp_v, act_v);
      end
    endfunction

    function void check_beat(nfa_view_t got);
      nfa_view_t want;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with none pending, active_mask %h", $time, got.mask);
        return;
      end
      want = due_q.pop_front();
      cmp("active_mask", want.mask, got.mask);
      cmp("unique_terminal", want.uniq, got.uniq);
      cmp("lowest_active", want.low, got.low);
      cmp("none_active", want.none, got.none);
      cmp("undo_ignored", want.ign, got.ign);
      cmp("history_count", want.cnt, got.cnt);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OPC_W-1:0]    in_opcode = '0;
  logic [SYM_IN_W-1:0] in_symbol = '0;
  logic [NODE_W-1:0]   in_from_node = '0;
  logic [NODE_W-1:0]   in_to_node = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DATA_W-1:0]   out_active_mask;
  logic                out_unique_terminal;
  logic [NODE_W-1:0]   out_lowest_active;
  logic                out_none_active;
  logic                out_undo_ignored;
  logic [HCNT_W-1:0]   out_history_count;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  nfa_scoreboard sb = new;

  nfa_active_set_stepper_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_symbol           (in_symbol),
    .in_from_node        (in_from_node),
    .in_to_node          (in_to_node),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_active_mask     (out_active_mask),
    .out_unique_terminal (out_unique_terminal),
    .out_lowest_active   (out_lowest_active),
    .out_none_active     (out_none_active),
    .out_undo_ignored    (out_undo_ignored),
    .out_history_count   (out_history_count)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: check accepted beats, then pick next ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        sb.check_beat(nfa_view_t'{out_active_mask, out_unique_terminal, out_lowest_active,
                                  out_none_active, out_undo_ignored, out_history_count});
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_beat(logic [OPC_W-1:0] op, logic [SYM_IN_W-1:0] sym,
                           logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_symbol    <= sym;
    in_from_node <= src;
    in_to_node   <= dst;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(op, sym, src, dst);
  endtask

  task automatic rand_beat();
    int r;
    logic [OPC_W-1:0] op;
    logic [SYM_IN_W-1:0] sym;
    r   = $urandom_range(0, 99);
    // small symbol alphabet most of the time so steps find edges
    sym = ($urandom_range(0, 3) == 0) ? SYM_IN_W'($urandom_range(0, 31))
                                      : SYM_IN_W'($urandom_range(0, 3));
    if (r < 40) op = OP_STEP;
    else if (r < 60) op = OP_UNDO;
    else if (r < 68) op = OP_RESTART;
    else if (r < 92) op = OP_ADD_EDGE;
    else if (r < 96) op = OP_SET_TERM;
    else op = OPC_W'($urandom_range(OP_RSVD_5, OP_RSVD_7));
    send_beat(op, sym, NODE_W'($urandom_range(0, 63)), NODE_W'($urandom_range(0, 63)));
  endtask

  // overfill the history, then unwind past empty
  task automatic history_burst(int n);
    repeat (n) send_beat(OP_STEP, SYM_IN_W'($urandom_range(0, 3)),
                         NODE_W'($urandom), NODE_W'($urandom));
    repeat (n + 1) send_beat(OP_UNDO, SYM_IN_W'($urandom),
                             NODE_W'($urandom), NODE_W'($urandom));
  endtask

  initial begin
    int cnt;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_beat(OP_UNDO, 0, 0, 0);
    send_beat(OP_STEP, 0, 0, 0);
    send_beat(OP_UNDO, 0, 0, 0);
    send_beat(OP_ADD_EDGE, 31, 0, 63);
    send_beat(OP_ADD_EDGE, 0, 63, 0);
    send_beat(OP_ADD_EDGE, 0, 0, 1);
    send_beat(OP_ADD_EDGE, 0, 0, 1);
    send_beat(OP_SET_TERM, 0, 63, 0);
    send_beat(OP_SET_TERM, 0, 1, 0);
    send_beat(OP_STEP, 31, 0, 0);
    send_beat(OP_STEP, 0, 0, 0);
    send_beat(OP_ADD_EDGE, 0, 0, 62);
    send_beat(OP_STEP, 0, 0, 0);
    send_beat(OP_SET_TERM, 0, 62, 0);
    send_beat(OP_RESTART, 0, 0, 0);
    send_beat(OP_RSVD_5, 31, 63, 63);
    send_beat(OP_RSVD_6, 0, 0, 0);
    send_beat(OP_RSVD_7, 31, 63, 63);
    send_beat(OP_UNDO, 0, 0, 0);
    send_beat(OP_UNDO, 0, 0, 0);
    send_beat(OP_UNDO, 0, 0, 0);
    send_beat(OP_UNDO, 0, 0, 0);
    send_beat(OP_STEP, 5, 63, 63);
    send_beat(OP_RESTART, 31, 63, 63);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = (p == 1 || p == 3) ? ((p == 1) ? 76 : 30) : 0;
      recv_stall_pct = (p == 2) ? 76 : ((p == 3) ? 30 : 0);
      if (p == 0) hold_req <= hold_req + 1;
      cnt = 0;
      while (cnt < PHASE_BEATS) begin
        if (p % 2 == 0 && cnt == 40) begin
          history_burst(BURST_STEPS);
          cnt += 2 * BURST_STEPS + 1;
        end else begin
          rand_beat();
          cnt++;
        end
      end
    end

    in_valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
